// ===== design/qts_pkg.sv =====
package qts_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CapW   = 11;

  localparam logic [CapW-1:0] CapReset = 11'd1024;

  localparam logic OpAdd = 1'b0;
  localparam logic OpDel = 1'b1;

  localparam logic CfgCapA = 1'b0;
  localparam logic CfgCapB = 1'b1;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  // decision for one item, handed from the controller to the result stage
  typedef struct packed {
    status_e status;
    logic    rd;      // successful delete: value comes from the memory read
  } res_t;

endpackage

// ===== design/qts_mem.sv =====
module qts_mem #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold the read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/qts_ctrl.sv =====
module qts_ctrl #(
  parameter int unsigned StackDepth = 1024,
  parameter int unsigned MemDepth   = 2 * StackDepth,
  parameter int unsigned AddrW      = $clog2(MemDepth),
  parameter int unsigned CntW       = $clog2(StackDepth + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       op_i,
  input  logic [qts_pkg::CapW-1:0]   cap_a_i,
  input  logic [qts_pkg::CapW-1:0]   cap_b_i,
  output qts_pkg::res_t              res_o,
  output logic                       we_o,
  output logic [AddrW-1:0]           waddr_o,
  output logic                       re_o,
  output logic [AddrW-1:0]           raddr_o
);

  logic [CntW-1:0]  in_cnt_q, in_cnt_d;
  logic [CntW-1:0]  out_cnt_q, out_cnt_d;
  logic [AddrW-1:0] head_q, head_d;
  logic [AddrW-1:0] tail_q, tail_d;
  logic [31:0]      cap_a_c, cap_b_c, cap_in;
  logic             room;
  qts_pkg::res_t    res;

  function automatic logic [31:0] clamp_cap(input logic [qts_pkg::CapW-1:0] c);
    logic [31:0] v;
    v = 32'(c);
    if (v == 32'd0) begin
      return 32'd1;
    end else if (v > 32'(StackDepth)) begin
      return 32'(StackDepth);
    end
    return v;
  endfunction

  function automatic logic [AddrW-1:0] ptr_inc(input logic [AddrW-1:0] p);
    return (p == AddrW'(MemDepth - 1)) ? '0 : p + AddrW'(1);
  endfunction

  assign cap_a_c = clamp_cap(cap_a_i);
  assign cap_b_c = clamp_cap(cap_b_i);
  assign cap_in  = (cap_a_c <= cap_b_c) ? cap_a_c : cap_b_c;
  assign room    = 32'(in_cnt_q) < cap_in;

  // Queue order is outbound then inbound, so one circular buffer holds both;
  // a fold only moves the count from inbound to outbound.
  always_comb begin
    res.status = qts_pkg::StOk;
    res.rd     = 1'b0;
    in_cnt_d   = in_cnt_q;
    out_cnt_d  = out_cnt_q;
    head_d     = head_q;
    tail_d     = tail_q;
    if (op_i == qts_pkg::OpAdd) begin
      if (room) begin
        in_cnt_d = in_cnt_q + CntW'(1);
        tail_d   = ptr_inc(tail_q);
      end else if (out_cnt_q == '0) begin
        out_cnt_d = in_cnt_q;
        in_cnt_d  = CntW'(1);
        tail_d    = ptr_inc(tail_q);
      end else begin
        res.status = qts_pkg::StFull;
      end
    end else begin
      if (out_cnt_q != '0) begin
        out_cnt_d = out_cnt_q - CntW'(1);
        res.rd    = 1'b1;
        head_d    = ptr_inc(head_q);
      end else if (in_cnt_q != '0) begin
        in_cnt_d = in_cnt_q - CntW'(1);
        res.rd   = 1'b1;
        head_d   = ptr_inc(head_q);
      end else begin
        res.status = qts_pkg::StEmpty;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      head_q    <= '0;
      tail_q    <= '0;
    end else if (accept_i) begin
      in_cnt_q  <= in_cnt_d;
      out_cnt_q <= out_cnt_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
    end
  end

  assign res_o   = res;
  assign we_o    = accept_i && (op_i == qts_pkg::OpAdd) && (res.status == qts_pkg::StOk);
  assign waddr_o = tail_q;
  assign re_o    = accept_i && res.rd;
  assign raddr_o = head_q;

  a_in_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(in_cnt_q) <= 32'(StackDepth))
    else $error("inbound count above stack depth");

  a_out_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(out_cnt_q) <= 32'(StackDepth))
    else $error("outbound count above stack depth");

  a_empty_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res.status == qts_pkg::StEmpty |=>
      in_cnt_q == '0 && out_cnt_q == '0 && $stable(head_q))
    else $error("empty delete changed state");

  a_ptr_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_cnt_q == '0 && out_cnt_q == '0 |-> head_q == tail_q)
    else $error("pointers disagree with empty counts");

endmodule

// ===== design/queue_from_two_stacks.sv =====
// Channel  | Dir | Handshake                     | Payload
// ---------+-----+-------------------------------+---------------------------
// in       | in  | in_valid_i / in_stall_o       | op_i, item_value_i
// out      | out | out_valid_o / out_stall_i     | status_o, out_value_o
// cfg      | in  | cfg_we_i (no wait)            | cfg_idx_i, cfg_data_i
//
// Cycles: one item per cycle while the result is not stalled; each result shows in the cycle after its transfer.
// A delete reads the single-port-read memory at transfer, and the read data
// register feeds out_value_o directly, so the memory read port sets the rate.
// Reset clears counts, pointers and the result slot and sets capacities to 1024;
// memory content needs no clearing pass, every read hits a written entry.
// A stalled result holds, and in_stall_o follows it in the same cycle.
module queue_from_two_stacks #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             op_i,
  input  logic signed [qts_pkg::ValueW-1:0] item_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic signed [qts_pkg::ValueW-1:0] out_value_o,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [qts_pkg::CapW-1:0]         cfg_data_i
);

  // Both stacks fit in one circular buffer: at most STACK_DEPTH outbound
  // plus STACK_DEPTH inbound entries can be live at once.
  localparam int unsigned MemDepth = 2 * STACK_DEPTH;
  localparam int unsigned AddrW    = $clog2(MemDepth);

  logic [qts_pkg::CapW-1:0] cap_a_q, cap_b_q;
  logic                     out_valid_q;
  qts_pkg::status_e         status_q;
  logic                     rd_q;
  logic                     accept;
  qts_pkg::res_t            res;
  logic                     we, re;
  logic [AddrW-1:0]         waddr, raddr;
  logic [qts_pkg::ValueW-1:0] rdata;

  // Take a new item whenever the result slot is free or drains this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Capacity registers; the user must write them only while the queue is idle, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_a_q <= qts_pkg::CapReset;
      cap_b_q <= qts_pkg::CapReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qts_pkg::CfgCapA: cap_a_q <= cfg_data_i;
        qts_pkg::CfgCapB: cap_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  qts_ctrl #(
    .StackDepth (STACK_DEPTH),
    .MemDepth   (MemDepth),
    .AddrW      (AddrW)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .op_i     (op_i),
    .cap_a_i  (cap_a_q),
    .cap_b_i  (cap_b_q),
    .res_o    (res),
    .we_o     (we),
    .waddr_o  (waddr),
    .re_o     (re),
    .raddr_o  (raddr)
  );

  qts_mem #(
    .Depth (MemDepth),
    .Width (qts_pkg::ValueW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (item_value_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Result slot: valid is control, status and select are payload. The memory
  // read register holds the dequeued value alongside until the next read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= res.status;
      rd_q     <= res.rd;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  // Drive zero for adds and for a delete that finds the queue empty.
  assign out_value_o = rd_q ? rdata : '0;

endmodule

// ===== tb/sv/tb_queue_from_two_stacks.sv =====
module tb_queue_from_two_stacks;
  import qts_pkg::*;

  localparam int unsigned QDepth    = 1024;
  localparam int unsigned IdleLimit = 2000;  // cycles without any transfer
  localparam int unsigned PhaseCnt  = 15;

  typedef struct packed {
    logic                     op;
    logic signed [ValueW-1:0] value;
  } access_t;

  typedef struct packed {
    status_e                  status;
    logic signed [ValueW-1:0] value;
  } outcome_t;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_stall_o;
  logic                     op_i         = OpAdd;
  logic signed [ValueW-1:0] item_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i  = 1'b0;
  logic [1:0]               status_o;
  logic signed [ValueW-1:0] out_value_o;
  logic                     cfg_we_i     = 1'b0;
  logic                     cfg_idx_i    = CfgCapA;
  logic [CapW-1:0]          cfg_data_i   = '0;

  // Shadow of the queue: two stacks with their fill counts and capacities.
  logic signed [ValueW-1:0] inbound_mem  [QDepth];
  logic signed [ValueW-1:0] outbound_mem [QDepth];
  int unsigned              inbound_cnt  = 0;
  int unsigned              outbound_cnt = 0;
  logic [CapW-1:0]          cap_a_m      = CapReset;
  logic [CapW-1:0]          cap_b_m      = CapReset;

  access_t     access_q[$];  // accesses waiting to be offered
  outcome_t    due_q[$];     // outcomes predicted, not yet seen
  bit          in_calm      = 1'b0;
  bit          out_calm     = 1'b0;
  logic [3:0]  in_wait      = '0;
  logic [3:0]  out_hold     = '0;
  int unsigned err_cnt      = 0;
  int unsigned idle_cycles  = 0;

  queue_from_two_stacks #(
    .STACK_DEPTH(QDepth)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .item_value_i (item_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .out_value_o  (out_value_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Zero means one slot, anything above the stack depth means the full stack depth.
  function automatic int unsigned usable_cap(logic [CapW-1:0] c);
    if (c == 0) return 1;
    if (c > QDepth) return QDepth;
    return 32'(c);
  endfunction

  // Apply one access to the shadow stacks and return the outcome it must give.
  function automatic outcome_t queue_access(access_t a);
    outcome_t    r;
    int unsigned cap_in;
    int unsigned k;
    r.status = StOk;
    r.value  = '0;
    cap_in = usable_cap(cap_a_m) <= usable_cap(cap_b_m) ? usable_cap(cap_a_m)
                                                        : usable_cap(cap_b_m);
    if (a.op == OpAdd) begin
      if (inbound_cnt < cap_in) begin
        inbound_mem[inbound_cnt] = a.value;
        inbound_cnt++;
      end else if (outbound_cnt == 0) begin
        // Move the whole inbound stack over, reversed, even past the outbound
        // capacity; then start the inbound stack afresh with the new item.
        for (k = 0; k < inbound_cnt; k++)
          outbound_mem[k] = inbound_mem[inbound_cnt - 1 - k];
        outbound_cnt   = inbound_cnt;
        inbound_mem[0] = a.value;
        inbound_cnt    = 1;
      end else begin
        r.status = StFull;
      end
    end else if (outbound_cnt > 0) begin
      outbound_cnt--;
      r.value = outbound_mem[outbound_cnt];
    end else if (inbound_cnt > 0) begin
      // Take the bottom of the inbound stack and slide the rest down.
      r.value = inbound_mem[0];
      for (k = 1; k < inbound_cnt; k++)
        inbound_mem[k - 1] = inbound_mem[k];
      inbound_cnt--;
    end else begin
      r.status = StEmpty;
    end
    return r;
  endfunction

  function automatic logic [3:0] draw_gap(bit calm);
    return calm ? 4'd0 : 4'($urandom_range(10, 0));
  endfunction

  function automatic access_t rand_access(int unsigned add_pct);
    access_t a;
    a.op = ($urandom_range(99, 0) < add_pct) ? OpAdd : OpDel;
    case ($urandom_range(7, 0))
      0:       a.value = 32'sh8000_0000;
      1:       a.value = 32'sh7fff_ffff;
      2:       a.value = -32'sd1;
      3:       a.value = '0;
      default: a.value = $urandom;
    endcase
    return a;
  endfunction

  task automatic push_access(logic op, logic signed [ValueW-1:0] value);
    access_q.push_back('{op: op, value: value});
  endtask

  // Hold until nothing is queued, offered or still due from the block.
  // Sample on the falling edge so the clocked driver and monitor have settled.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (access_q.size() != 0 || in_valid_i || due_q.size() != 0);
  endtask

  // Write one capacity register and mirror it in the shadow.
  task automatic write_cap(logic idx, logic [CapW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == CfgCapA) cap_a_m = val;
    else cap_b_m = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Input driver: predict each transfer as it happens, then wait the drawn
  // gap before offering the next access. The payload holds while stalled.
  always @(posedge clk_i) begin : drive_in
    logic [3:0] wait_n;
    access_t    nxt;
    if (rst_ni) begin
      wait_n = in_wait;
      if (in_valid_i && !in_stall_o) begin
        due_q.push_back(queue_access('{op: op_i, value: item_value_i}));
        wait_n = draw_gap(in_calm);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (wait_n != 0) begin
          in_valid_i <= 1'b0;
          in_wait    <= wait_n - 4'd1;
        end else if (access_q.size() != 0) begin
          nxt = access_q.pop_front();
          in_valid_i   <= 1'b1;
          op_i         <= nxt.op;
          item_value_i <= nxt.value;
          in_wait      <= '0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each result transfer against the oldest outcome
  // due, then hold out_stall_i for the drawn gap.
  always @(posedge clk_i) begin : watch_out
    logic [3:0] hold_n;
    outcome_t   want;
    if (rst_ni) begin
      hold_n = out_hold;
      if (out_valid_o && !out_stall_i) begin
        if (due_q.size() == 0) begin
          $error("unexpected result: status %0d out_value %0d", status_o, out_value_o);
          err_cnt++;
        end else begin
          want = due_q.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            err_cnt++;
          end
          if (out_value_o !== want.value) begin
            $error("out_value: expected %0d, got %0d", want.value, out_value_o);
            err_cnt++;
          end
        end
        hold_n = draw_gap(out_calm);
      end
      if (hold_n != 0) begin
        out_stall_i <= 1'b1;
        out_hold    <= hold_n - 4'd1;
      end else begin
        out_stall_i <= 1'b0;
        out_hold    <= '0;
      end
    end
  end

  // Watchdog: give up when neither side has moved for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IdleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : run
    int unsigned     n_items;
    int unsigned     add_pct;
    logic [CapW-1:0] ca;
    logic [CapW-1:0] cb;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset capacities: delete on an empty queue, extreme values, then
    // deletes served from the bottom of the inbound stack.
    push_access(OpDel, 32'sh1234_5678);
    push_access(OpAdd, 32'sh7fff_ffff);
    push_access(OpAdd, 32'sh8000_0000);
    push_access(OpAdd, '0);
    push_access(OpAdd, -32'sd1);
    push_access(OpAdd, 32'sh5555_5555);
    push_access(OpAdd, 32'shaaaa_aaaa);
    repeat (3) push_access(OpDel, '0);
    wait_drained();

    // Shrink to one inbound slot with three items still held: the next add
    // moves all three past the outbound capacity, the one after finds the
    // queue full, and the deletes drain it down to empty.
    write_cap(CfgCapA, 11'd2);
    write_cap(CfgCapB, 11'd0);
    push_access(OpAdd, 32'sh0bad_cafe);
    push_access(OpAdd, 32'sh7777_0001);
    repeat (5) push_access(OpDel, -32'sd1);

    for (int unsigned ph = 0; ph < PhaseCnt; ph++) begin
      wait_drained();
      case (ph % 6)
        0: begin
          ca = CapW'($urandom_range(8, 1));
          cb = CapW'($urandom_range(8, 1));
        end
        1: begin
          ca = '0;
          cb = '1;
        end
        2: begin
          ca = '1;
          cb = CapReset;
        end
        3: begin
          ca = CapW'($urandom_range(40, 1));
          cb = CapW'($urandom_range(2047, 0));
        end
        4: begin
          ca = 11'd1;
          cb = 11'd1;
        end
        default: begin
          ca = CapW'($urandom_range(2047, 0));
          cb = CapW'($urandom_range(3, 0));
        end
      endcase
      write_cap(CfgCapA, ca);
      write_cap(CfgCapB, cb);
      in_calm  = ($urandom_range(3, 0) == 0);
      out_calm = ($urandom_range(3, 0) == 0);
      case ($urandom_range(3, 0))
        0:       add_pct = 35;
        1:       add_pct = 50;
        2:       add_pct = 65;
        default: add_pct = 80;
      endcase
      n_items = $urandom_range(100, 70);
      repeat (n_items) access_q.push_back(rand_access(add_pct));
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && due_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
